// File: rtl/trc_pkg.sv
package trc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned INDEX_W   = 3;
    localparam int unsigned COUNT_W   = 5;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_FORMAT_VERSION = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PRESET_LIMIT   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_MAX_SECONDS    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_RUNNING_CODE   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_PAUSED_CODE    = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  FORMAT_VERSION_RST = 8'd1;
    localparam logic [8:0]  PRESET_LIMIT_RST   = 9'd8;
    localparam logic [31:0] MAX_SECONDS_RST    = 32'd86400;
    localparam logic [7:0]  RUNNING_CODE_RST   = 8'd0;
    localparam logic [7:0]  PAUSED_CODE_RST    = 8'd1;

    // Record layout and hash constants.
    localparam logic [31:0]        RECORD_MAGIC = 32'h4d54584e;
    localparam logic [31:0]        HASH_BASIS   = 32'd2166136261;
    localparam logic [31:0]        HASH_PRIME   = 32'd16777619;
    localparam logic [COUNT_W-1:0] HASHED_LEN   = 5'd24;
    localparam logic [COUNT_W-1:0] LAST_POS     = 5'd27;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd31;

endpackage

// File: rtl/trc_if.sv
interface trc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface trc_result_if;
    logic        valid;
    logic        ready;
    logic        loaded;
    logic        is_paused;
    logic [7:0]  preset_number;
    logic [63:0] deadline;
    logic [31:0] remaining;
    logic [31:0] total;

    modport source (output valid, output loaded, output is_paused, output preset_number,
                    output deadline, output remaining, output total, input ready);
    modport sink   (input valid, input loaded, input is_paused, input preset_number,
                    input deadline, input remaining, input total, output ready);
endinterface

// File: rtl/timer_record_checker_top.sv
// A record's result is registered after its last byte leaves the input stage.
// Throughput: one byte per cycle, but a last byte waits on a stalled result register;
// the prime multiply of the hash and the field checks each sit between two registers.
// Reset (rst_n, asynchronous, active low) empties the input and result stages,
// restores the configuration defaults and starts a fresh record.
module timer_record_checker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [trc_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [trc_pkg::DATA_W-1:0]    cfg_data,
    trc_byte_if.sink                      rec_in,
    trc_result_if.source                  res_out
);
    import trc_pkg::*;

    // Configuration registers.
    logic [7:0]  format_version_reg;
    logic [8:0]  preset_limit_reg;
    logic [31:0] max_seconds_reg;
    logic [7:0]  running_code_reg;
    logic [7:0]  paused_code_reg;

    // Input stage: one registered byte transaction.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Record collection state.
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [31:0]        hash_reg,      hash_next;
    logic [31:0]        header_reg,    header_next;
    logic [7:0]         version_reg,   version_next;
    logic [7:0]         phase_reg,     phase_next;
    logic [7:0]         preset_reg,    preset_next;
    logic [7:0]         pad_reg,       pad_next;
    logic [63:0]        deadline_reg,  deadline_next;
    logic [31:0]        remaining_reg, remaining_next;
    logic [31:0]        total_reg,     total_next;
    logic [31:0]        sum_reg,       sum_next;

    // Result stage.
    logic        res_valid_reg;
    logic        res_loaded_reg;
    logic        res_paused_reg;
    logic [7:0]  res_preset_reg;
    logic [63:0] res_deadline_reg;
    logic [31:0] res_remaining_reg;
    logic [31:0] res_total_reg;

    logic        out_free;
    logic        stage_fire;
    logic        finish;
    logic [31:0] hash_prod;
    logic        frame_ok;
    logic        limits_ok;
    logic        is_running;
    logic        is_pause;
    logic        running_ok;
    logic        paused_ok;
    logic        record_ok;

    // The result register can take a new value when it is empty or being drained.
    // A byte that does not end a record never waits on the result side.
    assign out_free   = !res_valid_reg || res_out.ready;
    assign stage_fire = in_valid_reg && (!in_last_reg || out_free);
    assign finish     = stage_fire && in_last_reg;
    assign rec_in.ready = !in_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_version_reg <= FORMAT_VERSION_RST;
            preset_limit_reg   <= PRESET_LIMIT_RST;
            max_seconds_reg    <= MAX_SECONDS_RST;
            running_code_reg   <= RUNNING_CODE_RST;
            paused_code_reg    <= PAUSED_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT_VERSION: format_version_reg <= cfg_data[7:0];
                REG_PRESET_LIMIT:   preset_limit_reg   <= cfg_data[8:0];
                REG_MAX_SECONDS:    max_seconds_reg    <= cfg_data[31:0];
                REG_RUNNING_CODE:   running_code_reg   <= cfg_data[7:0];
                REG_PAUSED_CODE:    paused_code_reg    <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rec_in.ready)
        begin
            in_valid_reg <= rec_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_in.valid && rec_in.ready)
        begin
            in_byte_reg <= rec_in.data_byte;
            in_last_reg <= rec_in.last_byte;
        end
    end

    // FNV-1a step; the product is kept to its low 32 bits.
    assign hash_prod = (hash_reg ^ {24'd0, in_byte_reg}) * HASH_PRIME;

    // Place the staged byte into the field that its position selects. Fields start
    // at zero for each record, so writing a byte lane equals OR-ing it in.
    always_comb
    begin
        hash_next      = hash_reg;
        header_next    = header_reg;
        version_next   = version_reg;
        phase_next     = phase_reg;
        preset_next    = preset_reg;
        pad_next       = pad_reg;
        deadline_next  = deadline_reg;
        remaining_next = remaining_reg;
        total_next     = total_reg;
        sum_next       = sum_reg;
        count_next     = (count_reg == COUNT_MAX) ? count_reg : count_reg + 5'd1;

        if (count_reg < HASHED_LEN)
        begin
            hash_next = hash_prod;
        end

        if (count_reg inside {[5'd0:5'd3]})
        begin
            header_next[8*count_reg[1:0] +: 8] = in_byte_reg;
        end
        else if (count_reg == 5'd4)
        begin
            version_next = in_byte_reg;
        end
        else if (count_reg == 5'd5)
        begin
            phase_next = in_byte_reg;
        end
        else if (count_reg == 5'd6)
        begin
            preset_next = in_byte_reg;
        end
        else if (count_reg == 5'd7)
        begin
            pad_next = in_byte_reg;
        end
        else if (count_reg inside {[5'd8:5'd15]})
        begin
            deadline_next[8*count_reg[2:0] +: 8] = in_byte_reg;
        end
        else if (count_reg inside {[5'd16:5'd19]})
        begin
            remaining_next[8*count_reg[1:0] +: 8] = in_byte_reg;
        end
        else if (count_reg inside {[5'd20:5'd23]})
        begin
            total_next[8*count_reg[1:0] +: 8] = in_byte_reg;
        end
        else if (count_reg inside {[5'd24:5'd27]})
        begin
            sum_next[8*count_reg[1:0] +: 8] = in_byte_reg;
        end
    end

    // Record checks on the fields as they stand once the final byte is placed.
    // The hash stops changing after byte 23, so hash_next equals hash_reg here.
    assign frame_ok  = (count_reg == LAST_POS) && (header_next == RECORD_MAGIC)
                       && (version_next == format_version_reg) && (pad_next == 8'd0)
                       && (sum_next == hash_next);
    assign limits_ok = ({1'b0, preset_next} < preset_limit_reg) && (total_next != 32'd0)
                       && (total_next <= max_seconds_reg);

    // When both phase codes are equal, the running interpretation wins.
    assign is_running = (phase_next == running_code_reg);
    assign is_pause   = !is_running && (phase_next == paused_code_reg);
    assign running_ok = (deadline_next != 64'd0) && (remaining_next == 32'd0);
    assign paused_ok  = (deadline_next == 64'd0) && (remaining_next != 32'd0)
                        && (remaining_next <= total_next)
                        && (remaining_next <= max_seconds_reg);
    assign record_ok  = frame_ok && limits_ok
                        && ((is_running && running_ok) || (is_pause && paused_ok));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hash_reg      <= HASH_BASIS;
            header_reg    <= '0;
            version_reg   <= '0;
            phase_reg     <= '0;
            preset_reg    <= '0;
            pad_reg       <= '0;
            deadline_reg  <= '0;
            remaining_reg <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
        end
        else if (finish)
        begin
            // The record is complete, so start over for the next one.
            count_reg     <= '0;
            hash_reg      <= HASH_BASIS;
            header_reg    <= '0;
            version_reg   <= '0;
            phase_reg     <= '0;
            preset_reg    <= '0;
            pad_reg       <= '0;
            deadline_reg  <= '0;
            remaining_reg <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
        end
        else if (stage_fire)
        begin
            count_reg     <= count_next;
            hash_reg      <= hash_next;
            header_reg    <= header_next;
            version_reg   <= version_next;
            phase_reg     <= phase_next;
            preset_reg    <= preset_next;
            pad_reg       <= pad_next;
            deadline_reg  <= deadline_next;
            remaining_reg <= remaining_next;
            total_reg     <= total_next;
            sum_reg       <= sum_next;
        end
    end

    // Result register. A rejected record reports all fields as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_loaded_reg    <= record_ok;
            res_paused_reg    <= record_ok && is_pause;
            res_preset_reg    <= record_ok ? preset_next    : 8'd0;
            res_deadline_reg  <= record_ok ? deadline_next  : 64'd0;
            res_remaining_reg <= record_ok ? remaining_next : 32'd0;
            res_total_reg     <= record_ok ? total_next     : 32'd0;
        end
    end

    assign res_out.valid         = res_valid_reg;
    assign res_out.loaded        = res_loaded_reg;
    assign res_out.is_paused     = res_paused_reg;
    assign res_out.preset_number = res_preset_reg;
    assign res_out.deadline      = res_deadline_reg;
    assign res_out.remaining     = res_remaining_reg;
    assign res_out.total         = res_total_reg;

    // A new result only appears right after the last byte of a record went through.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(finish))
        else $error("result appeared without a finished record");

    // Finishing a record always restarts the byte count.
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (count_reg == '0) && (hash_reg == HASH_BASIS))
        else $error("record state not cleared after last byte");

    // A loaded record always carries a nonzero total.
    a_loaded_total: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_loaded_reg) |-> (res_total_reg != 32'd0))
        else $error("loaded record with zero total");

    // A rejected record reports only zero fields.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_loaded_reg) |-> (!res_paused_reg && res_preset_reg == 8'd0
            && res_deadline_reg == 64'd0 && res_remaining_reg == 32'd0
            && res_total_reg == 32'd0))
        else $error("rejected record with nonzero fields");

endmodule

// File: sim/timer_record_checker_top_tb.sv
module timer_record_checker_top_tb;

    import trc_pkg::*;

    // A record always spans positions 0 up to and including LAST_POS.
    localparam int RECORD_BYTES = int'(LAST_POS) + 1;
    // The random part stops once about this many bytes have been queued.
    localparam int RANDOM_BYTES = 1300;
    // Records per random configuration phase.
    localparam int PHASE_RECORDS = 10;
    // Chance in a hundred that either side idles in a given cycle.
    localparam int IDLE_PERCENT = 28;

    // One byte transaction on the record input.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // One transaction on the result output.
    typedef struct packed {
        logic        loaded;
        logic        is_paused;
        logic [7:0]  preset_number;
        logic [63:0] deadline;
        logic [31:0] remaining;
        logic [31:0] total;
    } timer_result_t;

    // The fields of a stored record before it is serialized. The checksum is
    // computed when the bytes are laid out; sum_xor flips bits of it on purpose.
    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  phase;
        logic [7:0]  preset;
        logic [7:0]  pad;
        logic [63:0] deadline;
        logic [31:0] remaining;
        logic [31:0] total;
        logic [31:0] sum_xor;
    } timer_record_t;

    // The ways a random record can be spoiled so that the block rejects it.
    typedef enum int unsigned {
        FAULT_NONE,
        FAULT_MAGIC,
        FAULT_VERSION,
        FAULT_PAD,
        FAULT_CHECKSUM,
        FAULT_PRESET,
        FAULT_TOTAL,
        FAULT_TIMING,
        FAULT_PHASE,
        FAULT_SHORT,
        FAULT_LONG,
        FAULT_NOISE
    } fault_t;

    // Register indexes that the block does not decode; writes to them are dropped.
    localparam logic [INDEX_W-1:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [INDEX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]   cfg_data;

    trc_byte_if   rec_in ();
    trc_result_if res_out ();

    // Bytes waiting to be driven, and the verdicts the block still owes us.
    byte_item_t    byte_queue [$];
    timer_result_t verdict_q [$];

    // Bytes queued but not yet taken by the block. The stimulus raises it when
    // it queues a byte and the monitor lowers it when the transaction happens,
    // so it never races with the driver popping the queue.
    int unsigned bytes_pending = 0;
    int unsigned bytes_sent    = 0;
    int unsigned failures      = 0;
    logic        byte_taken    = 1'b0;
    logic        no_idle       = 1'b0;

    // Our copy of the configuration registers, starting at their reset values.
    logic [7:0]  want_version  = FORMAT_VERSION_RST;
    logic [8:0]  limit_presets = PRESET_LIMIT_RST;
    logic [31:0] max_secs      = MAX_SECONDS_RST;
    logic [7:0]  run_code      = RUNNING_CODE_RST;
    logic [7:0]  pause_code    = PAUSED_CODE_RST;

    // Our copy of the record being collected.
    logic [4:0]  rec_count     = '0;
    logic [31:0] rec_hash      = HASH_BASIS;
    logic [31:0] rec_magic     = '0;
    logic [7:0]  rec_version   = '0;
    logic [7:0]  rec_phase     = '0;
    logic [7:0]  rec_preset    = '0;
    logic [7:0]  rec_pad       = '0;
    logic [63:0] rec_deadline  = '0;
    logic [31:0] rec_remaining = '0;
    logic [31:0] rec_total     = '0;
    logic [31:0] rec_sum       = '0;

    timer_record_checker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_in    (rec_in),
        .res_out   (res_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One FNV-1a step: fold the byte in, then multiply by the prime, 32-bit wrap.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        return (h ^ {24'd0, b}) * HASH_PRIME;
    endfunction

    // Takes one accepted byte into our copy of the record. On the marked byte it
    // decides whether the record loads, queues the verdict and starts afresh.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [4:0]    pos;
        logic          ok;
        logic          paused;
        timer_result_t verdict;
        pos = rec_count;
        if (pos < HASHED_LEN)
            rec_hash = fnv_step(rec_hash, b);
        if (pos < 4)
            rec_magic[8*int'(pos[1:0]) +: 8] = b;
        else if (pos == 4)
            rec_version = b;
        else if (pos == 5)
            rec_phase = b;
        else if (pos == 6)
            rec_preset = b;
        else if (pos == 7)
            rec_pad = b;
        else if (pos < 16)
            rec_deadline[8*(int'(pos) - 8) +: 8] = b;
        else if (pos < 20)
            rec_remaining[8*int'(pos[1:0]) +: 8] = b;
        else if (pos < 24)
            rec_total[8*int'(pos[1:0]) +: 8] = b;
        else if (pos <= LAST_POS)
            rec_sum[8*int'(pos[1:0]) +: 8] = b;
        // The count sticks at its top value, so a long record can never
        // look as if it ended on the last position.
        if (pos != COUNT_MAX)
            rec_count = pos + 5'd1;
        if (last)
        begin
            ok = pos == LAST_POS && rec_magic == RECORD_MAGIC && rec_version == want_version
                 && rec_pad == 8'd0 && rec_sum == rec_hash
                 && {1'b0, rec_preset} < limit_presets
                 && rec_total != 32'd0 && rec_total <= max_secs;
            paused = 1'b0;
            if (ok)
            begin
                // When both codes are equal the running rules win.
                if (rec_phase == run_code)
                    ok = rec_deadline != 64'd0 && rec_remaining == 32'd0;
                else if (rec_phase == pause_code)
                begin
                    paused = 1'b1;
                    ok = rec_deadline == 64'd0 && rec_remaining != 32'd0
                         && rec_remaining <= rec_total && rec_remaining <= max_secs;
                end
                else
                    ok = 1'b0;
            end
            verdict = '0;
            if (ok)
                verdict = '{1'b1, paused, rec_preset, rec_deadline, rec_remaining, rec_total};
            verdict_q.push_back(verdict);
            rec_count     = '0;
            rec_hash      = HASH_BASIS;
            rec_magic     = '0;
            rec_version   = '0;
            rec_phase     = '0;
            rec_preset    = '0;
            rec_pad       = '0;
            rec_deadline  = '0;
            rec_remaining = '0;
            rec_total     = '0;
            rec_sum       = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // Monitor. Outputs are sampled at the rising edge, where a transaction
    // happens on a channel if valid and ready are both high. A result is
    // checked against the oldest verdict still owed; an input transaction
    // feeds our copy of the block.
    always @(posedge clk)
    begin : monitor
        timer_result_t want;
        byte_taken = rst_n && rec_in.valid && rec_in.ready;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result transaction arrived with no record outstanding");
                failures++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("loaded", want.loaded, res_out.loaded);
                check_field("is_paused", want.is_paused, res_out.is_paused);
                check_field("preset_number", want.preset_number, res_out.preset_number);
                check_field("deadline", want.deadline, res_out.deadline);
                check_field("remaining", want.remaining, res_out.remaining);
                check_field("total", want.total, res_out.total);
            end
        end
        if (byte_taken)
        begin
            absorb_byte(rec_in.data_byte, rec_in.last_byte);
            bytes_pending--;
        end
    end

    // Driver. Inputs change at the falling edge. A byte stays on the bus until
    // the block takes it; only then may the next one go out, or the source
    // idle for a cycle. The result side drops ready at random as well. Each
    // signal gets exactly one assignment here per falling edge.
    always @(negedge clk)
    begin : driver
        byte_item_t item;
        logic       hold;
        hold           = (rec_in.valid === 1'b1) && !byte_taken;
        item.data_byte = rec_in.data_byte;
        item.last_byte = rec_in.last_byte;
        if (!hold)
        begin
            // Idle cycles carry junk, which the block must not look at.
            item.data_byte = 8'($urandom);
            item.last_byte = 1'($urandom);
            if (rst_n && byte_queue.size() != 0
                && (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                item = byte_queue.pop_front();
                hold = 1'b1;
            end
        end
        rec_in.valid     <= hold;
        rec_in.data_byte <= item.data_byte;
        rec_in.last_byte <= item.last_byte;
        res_out.ready    <= no_idle || $urandom_range(0, 99) >= IDLE_PERCENT;
    end

    // Number from 1 to hi, with the two ends picked more often than chance would.
    function automatic logic [31:0] pick_upto(input logic [31:0] hi);
        case ($urandom_range(0, 7))
            0:       return 32'd1;
            1:       return hi;
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    // A record that passes every check under the current configuration.
    function automatic timer_record_t good_record(input logic paused);
        timer_record_t r;
        r         = '0;
        r.magic   = RECORD_MAGIC;
        r.version = want_version;
        r.phase   = paused ? pause_code : run_code;
        case ($urandom_range(0, 5))
            0:       r.preset = 8'd0;
            1:       r.preset = 8'(limit_presets - 9'd1);
            default: r.preset = 8'($urandom_range(0, limit_presets - 1));
        endcase
        r.total = pick_upto(max_secs);
        if (paused)
            r.remaining = pick_upto(r.total);
        else
        begin
            case ($urandom_range(0, 5))
                0:       r.deadline = 64'd1;
                1:       r.deadline = '1;
                default: r.deadline = {$urandom, $urandom};
            endcase
            if (r.deadline == 64'd0)
                r.deadline = 64'd1;
        end
        return r;
    endfunction

    // Lays the record out little-endian, appends its checksum and queues the
    // first len bytes. Past the end of the layout it sends random bytes. The
    // final byte carries the end mark.
    task automatic queue_record(input timer_record_t r, input int len);
        logic [7:0]  img [RECORD_BYTES];
        logic [31:0] sum;
        byte_item_t  item;
        for (int i = 0; i < 4; i++)
        begin
            img[i]      = r.magic[8*i +: 8];
            img[16 + i] = r.remaining[8*i +: 8];
            img[20 + i] = r.total[8*i +: 8];
        end
        img[4] = r.version;
        img[5] = r.phase;
        img[6] = r.preset;
        img[7] = r.pad;
        for (int i = 0; i < 8; i++)
            img[8 + i] = r.deadline[8*i +: 8];
        sum = HASH_BASIS;
        for (int i = 0; i < int'(HASHED_LEN); i++)
            sum = fnv_step(sum, img[i]);
        sum = sum ^ r.sum_xor;
        for (int i = 0; i < 4; i++)
            img[24 + i] = sum[8*i +: 8];
        for (int i = 0; i < len; i++)
        begin
            item.data_byte = (i < RECORD_BYTES) ? img[i] : 8'($urandom);
            item.last_byte = (i == len - 1);
            byte_queue.push_back(item);
            bytes_pending++;
            bytes_sent++;
        end
    endtask

    // Mostly well-formed records with random content, the rest spoiled in one
    // chosen way or plain noise.
    task automatic queue_random_record();
        timer_record_t r;
        fault_t        fault;
        int            len;
        r     = good_record(1'($urandom));
        len   = RECORD_BYTES;
        fault = FAULT_NONE;
        if ($urandom_range(0, 99) >= 60)
            fault = fault_t'($urandom_range(FAULT_MAGIC, FAULT_NOISE));
        case (fault)
            FAULT_MAGIC:    r.magic = r.magic ^ (32'd1 << $urandom_range(0, 31));
            FAULT_VERSION:  r.version = r.version + 8'($urandom_range(1, 255));
            FAULT_PAD:      r.pad = 8'($urandom_range(1, 255));
            FAULT_CHECKSUM: r.sum_xor = 32'd1 << $urandom_range(0, 31);
            FAULT_PRESET:
            begin
                // With a limit of 256 every preset is legal and the record stays good.
                if (limit_presets < 9'd256)
                    r.preset = 8'($urandom_range(limit_presets, 255));
            end
            FAULT_TOTAL:
            begin
                if (max_secs == '1 || $urandom_range(0, 1) == 0)
                    r.total = 32'd0;
                else
                    r.total = $urandom_range(max_secs + 32'd1, 32'hFFFF_FFFF);
            end
            FAULT_TIMING:
            begin
                // Break the phase rules: a missing or stray deadline, a missing
                // or stray remaining time, or more time left than the total.
                case ($urandom_range(0, 2))
                    0:       r.deadline = (r.deadline == 64'd0) ? {$urandom, $urandom} | 64'd1
                                                                : 64'd0;
                    1:       r.remaining = (r.remaining == 32'd0) ? pick_upto(r.total) : 32'd0;
                    default: r.remaining = r.total + 32'd1;
                endcase
            end
            FAULT_PHASE:
            begin
                r.phase = 8'($urandom);
                while (r.phase == run_code || r.phase == pause_code)
                    r.phase = 8'($urandom);
            end
            FAULT_SHORT:    len = $urandom_range(1, RECORD_BYTES - 1);
            FAULT_LONG:     len = $urandom_range(RECORD_BYTES + 1, 40);
            FAULT_NOISE:
            begin
                r.magic     = $urandom;
                r.version   = 8'($urandom);
                r.phase     = 8'($urandom);
                r.preset    = 8'($urandom);
                r.pad       = 8'($urandom);
                r.deadline  = {$urandom, $urandom};
                r.remaining = $urandom;
                r.total     = $urandom;
                r.sum_xor   = $urandom;
                len         = $urandom_range(1, 40);
            end
            default: ;
        endcase
        queue_record(r, len);
    endtask

    // Waits until every queued byte has been taken and every verdict has come
    // back, then lets the input and result stages settle.
    task automatic wait_quiet();
        while (bytes_pending != 0 || verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write, held for a single clock. Our copy keeps only the
    // bits each register holds. The caller lowers the write enable after the
    // last write of a group.
    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_FORMAT_VERSION: want_version  = value[7:0];
            REG_PRESET_LIMIT:   limit_presets = value[8:0];
            REG_MAX_SECONDS:    max_secs      = value;
            REG_RUNNING_CODE:   run_code      = value[7:0];
            REG_PAUSED_CODE:    pause_code    = value[7:0];
            default: ;
        endcase
    endtask

    // Writes all five registers. Half the time the unused upper bits of the
    // data carry junk, which the block must drop.
    task automatic apply_config(input logic [7:0] version, input logic [8:0] limit,
                                input logic [31:0] max_s, input logic [7:0] run_c,
                                input logic [7:0] pause_c);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? $urandom : 32'd0;
        write_reg(REG_FORMAT_VERSION, {junk[31:8], version});
        write_reg(REG_PRESET_LIMIT, {junk[31:9], limit});
        write_reg(REG_MAX_SECONDS, max_s);
        write_reg(REG_RUNNING_CODE, {junk[31:8], run_c});
        write_reg(REG_PAUSED_CODE, {junk[31:8], pause_c});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [7:0]  version;
        logic [8:0]  limit;
        logic [31:0] max_s;
        logic [7:0]  run_c;
        logic [7:0]  pause_c;
        case ($urandom_range(0, 3))
            0:       version = 8'd0;
            1:       version = 8'hFF;
            default: version = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       limit = 9'd1;
            1:       limit = 9'd256;
            default: limit = 9'($urandom_range(1, 256));
        endcase
        case ($urandom_range(0, 5))
            0:       max_s = 32'd1;
            1:       max_s = 32'hFFFF_FFFF;
            2:       max_s = MAX_SECONDS_RST;
            3:       max_s = $urandom_range(1, 1000);
            default: max_s = $urandom_range(1, 32'hFFFF_FFFF);
        endcase
        run_c   = 8'($urandom);
        pause_c = ($urandom_range(0, 3) == 0) ? run_c : 8'($urandom);
        apply_config(version, limit, max_s, run_c, pause_c);
    endtask

    // Stimulus. After reset, a directed set of records checks the edges of
    // each rule under the default configuration, then under extreme settings.
    // The random part follows, with a fresh configuration every few records
    // and one long stretch where neither side idles.
    initial
    begin : stimulus
        timer_record_t r;
        int unsigned   phase;
        int unsigned   directed_bytes;
        int unsigned   drain;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_FORMAT_VERSION;
        cfg_data          = '0;
        rec_in.valid      = 1'b0;
        rec_in.data_byte  = '0;
        rec_in.last_byte  = 1'b0;
        res_out.ready     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Defaults: version 1, presets below 8, at most one day.
        // A running record at the top of every range.
        r = good_record(1'b0);
        r.preset   = 8'd7;
        r.total    = MAX_SECONDS_RST;
        r.deadline = '1;
        queue_record(r, RECORD_BYTES);
        // A paused record with all of its time left.
        r = good_record(1'b1);
        r.preset    = 8'd0;
        r.total     = MAX_SECONDS_RST;
        r.remaining = MAX_SECONDS_RST;
        queue_record(r, RECORD_BYTES);
        // Wrong magic word, wrong version, nonzero pad, wrong checksum.
        r = good_record(1'b0);
        r.magic = ~RECORD_MAGIC;
        queue_record(r, RECORD_BYTES);
        r = good_record(1'b0);
        r.version = 8'd0;
        queue_record(r, RECORD_BYTES);
        r = good_record(1'b1);
        r.pad = 8'hFF;
        queue_record(r, RECORD_BYTES);
        r = good_record(1'b0);
        r.sum_xor = 32'h8000_0000;
        queue_record(r, RECORD_BYTES);
        // A record of a single byte, one a byte short, and one long enough
        // to pin the byte count at its top value.
        queue_record(good_record(1'b0), 1);
        queue_record(good_record(1'b0), RECORD_BYTES - 1);
        queue_record(good_record(1'b1), 35);
        // A phase byte that is neither code.
        r = good_record(1'b0);
        r.phase = 8'hFF;
        queue_record(r, RECORD_BYTES);
        // Total one past the maximum, a zero total, and a preset at the limit.
        r = good_record(1'b0);
        r.total = MAX_SECONDS_RST + 32'd1;
        queue_record(r, RECORD_BYTES);
        r = good_record(1'b0);
        r.total = 32'd0;
        queue_record(r, RECORD_BYTES);
        r = good_record(1'b1);
        r.preset = 8'd8;
        queue_record(r, RECORD_BYTES);
        wait_quiet();

        // Every register at its top value but the preset limit, set to 256; this also
        // makes both phase codes equal: the running rules then apply to that code.
        apply_config(8'hFF, 9'd256, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        r = good_record(1'b0);
        r.preset   = 8'hFF;
        r.total    = 32'hFFFF_FFFF;
        r.deadline = 64'd1;
        queue_record(r, RECORD_BYTES);
        r = good_record(1'b1);
        queue_record(r, RECORD_BYTES);
        wait_quiet();

        // Writes to undecoded indexes must leave the configuration alone.
        write_reg(REG_SPARE_LOW, $urandom);
        write_reg(REG_SPARE_HIGH, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        queue_record(good_record(1'b0), RECORD_BYTES);
        wait_quiet();

        // Bottom values, with a zero maximum so that nothing can load.
        apply_config(8'd0, 9'd1, 32'd0, 8'd0, 8'hFF);
        queue_record(good_record(1'b0), RECORD_BYTES);
        queue_record(good_record(1'b1), RECORD_BYTES);
        wait_quiet();

        directed_bytes = bytes_sent;
        phase = 0;
        while (bytes_sent - directed_bytes < RANDOM_BYTES)
        begin
            wait_quiet();
            no_idle = (phase == 2 || phase == 3);
            random_config();
            repeat (PHASE_RECORDS) queue_random_record();
            phase++;
        end
        no_idle = 1'b0;

        // Drain, with a bound, then let the pipeline run empty for a while so
        // that a stray result would still be caught.
        drain = 0;
        while ((bytes_pending != 0 || verdict_q.size() != 0) && drain < 5000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);
        if (bytes_pending != 0 || verdict_q.size() != 0)
        begin
            $error("%0d bytes and %0d expected results never went through",
                   bytes_pending, verdict_q.size());
            failures++;
        end
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop in case the block stops answering.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
